FILE: src/sscr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscr_pkg
// Sizes, register offsets, codes and reset tables of the SPI socket
// controller register file.
// ----------------------------------------------------------------------------
package sscr_pkg;

	localparam int NUM_SOCKETS  = 8;
	localparam int TX_BYTES     = 2048;
	localparam int RX_BYTES     = 2048;
	localparam int COMMON_BYTES = 64;
	localparam int SOCKET_BYTES = 48;

	localparam int SOCK_W  = (NUM_SOCKETS > 1) ? $clog2(NUM_SOCKETS) : 1;
	localparam int COM_AW  = $clog2(COMMON_BYTES);
	localparam int SOCK_OW = $clog2(SOCKET_BYTES);
	localparam int SK_AW   = SOCK_W + SOCK_OW;
	localparam int TX_OW   = $clog2(TX_BYTES);
	localparam int RX_OW   = $clog2(RX_BYTES);
	localparam int TX_AW   = SOCK_W + TX_OW;
	localparam int RX_AW   = SOCK_W + RX_OW;
	localparam int MAX_A   = (COM_AW > SK_AW) ? COM_AW : SK_AW;
	localparam int MAX_B   = (TX_AW > RX_AW) ? TX_AW : RX_AW;
	localparam int CLR_AW  = (MAX_A > MAX_B) ? MAX_A : MAX_B;

	// common register offsets
	localparam logic [7:0] C_SHAR    = 8'h09;
	localparam logic [7:0] C_RTR     = 8'h19;
	localparam logic [7:0] C_RCR     = 8'h1B;
	localparam logic [7:0] C_PHYCFG  = 8'h2E;
	localparam logic [7:0] C_VERSION = 8'h39;

	// socket register offsets
	localparam logic [7:0] S_MR    = 8'h00;
	localparam logic [7:0] S_CR    = 8'h01;
	localparam logic [7:0] S_IR    = 8'h02;
	localparam logic [7:0] S_SR    = 8'h03;
	localparam logic [7:0] S_TTL   = 8'h16;
	localparam logic [7:0] S_RXSZ  = 8'h1E;
	localparam logic [7:0] S_TXSZ  = 8'h1F;
	localparam logic [7:0] S_TXFSR = 8'h20;
	localparam logic [7:0] S_TXRD  = 8'h22;
	localparam logic [7:0] S_TXWR  = 8'h24;
	localparam logic [7:0] S_RXRSR = 8'h26;

	// socket status codes
	localparam logic [7:0] SR_CLOSED = 8'h00;
	localparam logic [7:0] SR_INIT   = 8'h13;
	localparam logic [7:0] SR_LISTEN = 8'h14;
	localparam logic [7:0] SR_ESTAB  = 8'h17;
	localparam logic [7:0] SR_UDP    = 8'h22;
	localparam logic [7:0] SR_MACRAW = 8'h42;

	// socket commands
	localparam logic [7:0] CMD_OPEN    = 8'h01;
	localparam logic [7:0] CMD_LISTEN  = 8'h02;
	localparam logic [7:0] CMD_CONNECT = 8'h04;
	localparam logic [7:0] CMD_CLOSE   = 8'h10;
	localparam logic [7:0] CMD_SEND    = 8'h20;
	localparam logic [7:0] CMD_RECV    = 8'h40;

	// socket modes
	localparam logic [3:0] MODE_TCP    = 4'h1;
	localparam logic [3:0] MODE_UDP    = 4'h2;
	localparam logic [3:0] MODE_MACRAW = 4'h4;

	localparam logic [7:0] IR_SENDOK = 8'h10;
	localparam logic [7:0] IDLE_BYTE = 8'hFF;

	localparam logic [15:0] TX_FREE = 16'(TX_BYTES);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_EXEC, ST_RDWAIT, ST_CMDRD, ST_CMDWR
	} state_t;

	typedef enum logic [1:0] {
		PH_ADDR_HI, PH_ADDR_LO, PH_CTRL, PH_DATA
	} phase_t;

	typedef enum logic [2:0] {
		SRC_ZERO, SRC_COM, SRC_SOCK, SRC_TX, SRC_RX
	} src_t;

	function automatic logic [7:0] com_init(input logic [7:0] a);
		logic [7:0] v;
		v = 8'h00;
		if (a == C_VERSION)              v = 8'h04;
		else if (a == C_SHAR)            v = 8'h02;
		else if (a == C_SHAR + 8'd5)     v = 8'h01;
		else if (a == C_PHYCFG)          v = 8'h87;
		else if (a == C_RTR)             v = 8'h07;
		else if (a == C_RTR + 8'd1)      v = 8'hD0;
		else if (a == C_RCR)             v = 8'h08;
		return v;
	endfunction

	function automatic logic [7:0] sock_init(input logic [7:0] a);
		logic [7:0] v;
		v = 8'h00;
		if (a == S_TTL)                  v = 8'd128;
		else if (a == S_RXSZ)            v = 8'(RX_BYTES >> 10);
		else if (a == S_TXSZ)            v = 8'(TX_BYTES >> 10);
		else if (a == S_TXFSR)           v = TX_FREE[15:8];
		else if (a == S_TXFSR + 8'd1)    v = TX_FREE[7:0];
		return v;
	endfunction

endpackage

FILE: src/sscr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sscr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: src/spi_socket_controller_registers.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_socket_controller_registers
// SPI frame decoder over the common, socket, transmit and receive stores.
// ----------------------------------------------------------------------------
// select events, header bytes and writes: strobe registered from the EXEC state
// read data bytes: strobe registered from the RDWAIT state, after the registered RAM read
// socket command writes then keep busy through CMDRD and CMDWR: one socket RAM port
// does five reads and nine write steps in turn; no new transaction is taken while busy
// after reset busy stays high in ST_CLEAR while every store is swept to its reset
// contents; the receiver cannot stall the strobe
module spi_socket_controller_registers
	import sscr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       command,
	input  logic       cs_level,
	input  logic [7:0] mosi,
	output logic       valid,
	output logic [7:0] miso
);

	state_t state_q, state_d;
	phase_t phase_q;
	src_t   src_q, tgt;

	logic              cs_q, wr_q;
	logic [15:0]       addr_q;
	logic [4:0]        bsb_q;
	logic              cmd_q, lvl_q;
	logic [7:0]        mosi_q;
	logic [CLR_AW-1:0] clr_q;
	logic [3:0]        step_q;
	logic [7:0]        mr_q, sr_q, ir_q, wr0_q, wr1_q, opc_q;

	logic [4:0]        bsb_m1;
	logic [SOCK_W-1:0] sock_sel;
	logic              sock_ok, data_hit, cmd_hit;

	logic              com_we, sk_we, tx_we, rx_we;
	logic [COM_AW-1:0] com_addr;
	logic [SK_AW-1:0]  sk_addr;
	logic [TX_AW-1:0]  tx_addr;
	logic [RX_AW-1:0]  rx_addr;
	logic [7:0]        com_wd, sk_wd, tx_wd, rx_wd;
	logic [7:0]        com_rd, sk_rd, tx_rd, rx_rd;

	logic [7:0]        rd_off, wr_off, wr_val;
	logic              wr_en;
	logic [3:0]        mode;

	// block decode
	assign bsb_m1   = bsb_q - 5'd1;
	assign sock_sel = bsb_m1[SOCK_W+1:2];
	assign sock_ok  = {1'b0, bsb_m1[4:2]} < 4'(NUM_SOCKETS);
	assign data_hit = cmd_q && cs_q && (phase_q == PH_DATA);
	assign mode     = mr_q[3:0];

	always_comb begin
		tgt = SRC_ZERO;
		if (bsb_q == 5'd0) begin
			if (addr_q < 16'(COMMON_BYTES)) tgt = SRC_COM;
		end else if (sock_ok) begin
			unique case (bsb_m1[1:0])
				2'd0: if (addr_q < 16'(SOCKET_BYTES)) tgt = SRC_SOCK;
				2'd1: tgt = SRC_TX;
				2'd2: tgt = SRC_RX;
				default: tgt = SRC_ZERO;
			endcase
		end
	end

	assign cmd_hit = data_hit && wr_q && (tgt == SRC_SOCK) &&
		(addr_q[7:0] == S_CR) && (addr_q[15:8] == 8'd0) && (mosi_q != 8'd0);

	// command sequence tables
	always_comb begin
		unique case (step_q)
			4'd0:    rd_off = S_MR;
			4'd1:    rd_off = S_SR;
			4'd2:    rd_off = S_IR;
			4'd3:    rd_off = S_TXWR;
			default: rd_off = S_TXWR + 8'd1;
		endcase
	end

	always_comb begin
		wr_off = S_CR;
		wr_val = 8'd0;
		wr_en  = 1'b0;
		unique case (step_q)
			4'd0: begin
				wr_off = S_SR;
				if (opc_q == CMD_OPEN) begin
					wr_en = (mode == MODE_TCP) || (mode == MODE_UDP) ||
						(mode == MODE_MACRAW);
					wr_val = (mode == MODE_TCP) ? SR_INIT :
						(mode == MODE_UDP) ? SR_UDP : SR_MACRAW;
				end else if (opc_q == CMD_LISTEN) begin
					wr_en  = sr_q == SR_INIT;
					wr_val = SR_LISTEN;
				end else if (opc_q == CMD_CONNECT) begin
					wr_en  = sr_q == SR_INIT;
					wr_val = SR_ESTAB;
				end else if (opc_q == CMD_CLOSE) begin
					wr_en  = 1'b1;
					wr_val = SR_CLOSED;
				end
			end
			4'd1: begin
				wr_off = S_TXFSR;
				wr_val = TX_FREE[15:8];
				wr_en  = (opc_q == CMD_OPEN) || (opc_q == CMD_SEND);
			end
			4'd2: begin
				wr_off = S_TXFSR + 8'd1;
				wr_val = TX_FREE[7:0];
				wr_en  = (opc_q == CMD_OPEN) || (opc_q == CMD_SEND);
			end
			4'd3: begin
				wr_off = S_TXRD;
				wr_val = wr0_q;
				wr_en  = opc_q == CMD_SEND;
			end
			4'd4: begin
				wr_off = S_TXRD + 8'd1;
				wr_val = wr1_q;
				wr_en  = opc_q == CMD_SEND;
			end
			4'd5: begin
				wr_off = S_IR;
				wr_val = ir_q | IR_SENDOK;
				wr_en  = opc_q == CMD_SEND;
			end
			4'd6: begin
				wr_off = S_RXRSR;
				wr_en  = opc_q == CMD_RECV;
			end
			4'd7: begin
				wr_off = S_RXRSR + 8'd1;
				wr_en  = opc_q == CMD_RECV;
			end
			default: begin
				wr_off = S_CR;
				wr_en  = 1'b1;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE:   if (start) state_d = ST_EXEC;
			ST_EXEC: begin
				priority if (data_hit && !wr_q) state_d = ST_RDWAIT;
				else if (cmd_hit)               state_d = ST_CMDRD;
				else                            state_d = ST_IDLE;
			end
			ST_RDWAIT: state_d = ST_IDLE;
			ST_CMDRD:  if (step_q == 4'd5) state_d = ST_CMDWR;
			ST_CMDWR:  if (step_q == 4'd8) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		com_we   = 1'b0;
		sk_we    = 1'b0;
		tx_we    = 1'b0;
		rx_we    = 1'b0;
		com_addr = addr_q[COM_AW-1:0];
		sk_addr  = {sock_sel, addr_q[SOCK_OW-1:0]};
		tx_addr  = {sock_sel, addr_q[TX_OW-1:0]};
		rx_addr  = {sock_sel, addr_q[RX_OW-1:0]};
		com_wd   = mosi_q;
		sk_wd    = mosi_q;
		tx_wd    = mosi_q;
		rx_wd    = mosi_q;
		unique case (state_q)
			ST_CLEAR: begin
				com_addr = clr_q[COM_AW-1:0];
				sk_addr  = clr_q[SK_AW-1:0];
				tx_addr  = clr_q[TX_AW-1:0];
				rx_addr  = clr_q[RX_AW-1:0];
				com_we   = (clr_q >> COM_AW) == '0;
				sk_we    = (clr_q >> SK_AW) == '0;
				tx_we    = (clr_q >> TX_AW) == '0;
				rx_we    = (clr_q >> RX_AW) == '0;
				com_wd   = com_init(8'(clr_q[COM_AW-1:0]));
				sk_wd    = sock_init(8'(clr_q[SOCK_OW-1:0]));
				tx_wd    = 8'd0;
				rx_wd    = 8'd0;
			end
			ST_EXEC: begin
				if (data_hit && wr_q) begin
					com_we = (tgt == SRC_COM) && (addr_q[7:0] != C_VERSION);
					sk_we  = tgt == SRC_SOCK;
					tx_we  = tgt == SRC_TX;
					rx_we  = tgt == SRC_RX;
				end
			end
			ST_CMDRD: sk_addr = {sock_sel, rd_off[SOCK_OW-1:0]};
			ST_CMDWR: begin
				sk_addr = {sock_sel, wr_off[SOCK_OW-1:0]};
				sk_we   = wr_en;
				sk_wd   = wr_val;
			end
			default: ;
		endcase
	end

	assign busy = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			phase_q <= PH_ADDR_HI;
			cs_q    <= 1'b0;
			wr_q    <= 1'b0;
			addr_q  <= 16'd0;
			bsb_q   <= 5'd0;
			clr_q   <= '0;
			step_q  <= 4'd0;
			valid   <= 1'b0;
		end else begin
			state_q <= state_d;
			valid   <= 1'b0;
			if (state_q != state_d) step_q <= 4'd0;
			else step_q <= step_q + 4'd1;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_EXEC) begin
				if (!cmd_q) begin
					cs_q <= lvl_q;
					if (lvl_q) phase_q <= PH_ADDR_HI;
				end else if (cs_q) begin
					unique case (phase_q)
						PH_ADDR_HI: begin
							addr_q  <= {mosi_q, 8'd0};
							phase_q <= PH_ADDR_LO;
						end
						PH_ADDR_LO: begin
							addr_q[7:0] <= mosi_q;
							phase_q     <= PH_CTRL;
						end
						PH_CTRL: begin
							bsb_q   <= mosi_q[7:3];
							wr_q    <= mosi_q[2];
							phase_q <= PH_DATA;
						end
						default: addr_q <= addr_q + 16'd1;
					endcase
				end
				if (!(data_hit && !wr_q)) valid <= 1'b1;
			end
			if (state_q == ST_RDWAIT) valid <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q  <= command;
			lvl_q  <= cs_level;
			mosi_q <= mosi;
		end
		if (state_q == ST_EXEC) begin
			src_q <= tgt;
			opc_q <= mosi_q;
			miso  <= IDLE_BYTE;
		end
		if (state_q == ST_RDWAIT) begin
			unique case (src_q)
				SRC_COM:  miso <= com_rd;
				SRC_SOCK: miso <= sk_rd;
				SRC_TX:   miso <= tx_rd;
				SRC_RX:   miso <= rx_rd;
				default:  miso <= 8'd0;
			endcase
		end
		if (state_q == ST_CMDRD) begin
			unique case (step_q)
				4'd1:    mr_q  <= sk_rd;
				4'd2:    sr_q  <= sk_rd;
				4'd3:    ir_q  <= sk_rd;
				4'd4:    wr0_q <= sk_rd;
				4'd5:    wr1_q <= sk_rd;
				default: ;
			endcase
		end
	end

	sscr_ram #(.WIDTH(8), .DEPTH(2 ** COM_AW)) u_com_ram (
		.clk(clk), .we(com_we), .addr(com_addr), .wdata(com_wd), .rdata(com_rd)
	);

	sscr_ram #(.WIDTH(8), .DEPTH(2 ** SK_AW)) u_sock_ram (
		.clk(clk), .we(sk_we), .addr(sk_addr), .wdata(sk_wd), .rdata(sk_rd)
	);

	sscr_ram #(.WIDTH(8), .DEPTH(2 ** TX_AW)) u_tx_ram (
		.clk(clk), .we(tx_we), .addr(tx_addr), .wdata(tx_wd), .rdata(tx_rd)
	);

	sscr_ram #(.WIDTH(8), .DEPTH(2 ** RX_AW)) u_rx_ram (
		.clk(clk), .we(rx_we), .addr(rx_addr), .wdata(rx_wd), .rdata(rx_rd)
	);

endmodule

FILE: src/sscr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscr_checker
// Port-level timing checks of the SPI socket controller register file.
// ----------------------------------------------------------------------------
module sscr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       command,
	input logic       cs_level,
	input logic [7:0] mosi,
	input logic       valid,
	input logic [7:0] miso
);

	// an accepted transaction holds the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after start");

	// a strobe always follows a cycle of work
	a_valid_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy))
		else $error("strobe without preceding work");

	// no strobe in the cycle right after acceptance
	a_no_early_valid: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !valid)
		else $error("strobe too early");

	// select events answer 0xff, registered from the EXEC state
	a_select_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !command |=> ##1 (valid && miso == 8'hFF))
		else $error("select event answer wrong");

endmodule

bind spi_socket_controller_registers sscr_checker u_sscr_checker (.*);
